// ===== rtl/ubr_pkg.sv =====
// Shared types and constants for the UART byte relay.
// No dependencies; every other rtl file but ubr_in_stage and ubr_checker refers to this package by scope.
package ubr_pkg;

	localparam int unsigned TICK_W   = 16;
	localparam int unsigned COUNT_W  = TICK_W + 1;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_RX_BIT_TICKS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TX_BIT_TICKS = 1'd1;

	localparam logic [TICK_W-1:0] RX_BIT_TICKS_RST = 16'd500;
	localparam logic [TICK_W-1:0] TX_BIT_TICKS_RST = 16'd104;

	localparam logic [7:0] INIT_BYTE = 8'h01;

	typedef struct packed {
		logic [TICK_W-1:0] rx_bit_ticks;
		logic [TICK_W-1:0] tx_bit_ticks;
	} ubr_cfg_t;

	typedef struct packed {
		logic       tx_level;
		logic       trigger_seen;
		logic [7:0] held_byte;
		logic       byte_changed;
		logic       byte_done;
	} ubr_result_t;

	// A computed wait of zero ticks counts as one tick.
	function automatic logic [COUNT_W-1:0] at_least_one(input logic [COUNT_W-1:0] v);
		at_least_one = (v == '0) ? COUNT_W'(1) : v;
	endfunction

endpackage

// ===== rtl/ubr_cfg.sv =====
// Configuration registers of the UART byte relay (bit periods).
// Depends on ubr_pkg.
module ubr_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ubr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ubr_pkg::TICK_W-1:0]     cfg_data,
	output ubr_pkg::ubr_cfg_t              cfg
);

	ubr_pkg::ubr_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rx_bit_ticks <= ubr_pkg::RX_BIT_TICKS_RST;
			cfg_q.tx_bit_ticks <= ubr_pkg::TX_BIT_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ubr_pkg::CFG_RX_BIT_TICKS: cfg_q.rx_bit_ticks <= cfg_data;
				ubr_pkg::CFG_TX_BIT_TICKS: cfg_q.tx_bit_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/ubr_core.sv =====
// Receive/transmit sequencer of the UART byte relay: one tick per step.
// Holds all line state; produces the result of the current tick combinationally.
// Depends on ubr_pkg.
module ubr_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  rx,
	input  logic                  trig,
	input  ubr_pkg::ubr_cfg_t     cfg,
	output ubr_pkg::ubr_result_t  res
);

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_RX_BITS = 3'd1,
		PH_RX_STOP = 3'd2,
		PH_TX_INIT = 3'd3,
		PH_TX_DATA = 3'd4
	} phase_t;

	phase_t                         phase_q, phase_n;
	logic [ubr_pkg::COUNT_W-1:0]    tick_q, tick_n, tick_dec;
	logic [3:0]                     bit_q, bit_n, bit_inc;
	logic [7:0]                     rxsh_q, rxsh_n;
	logic [7:0]                     held_q, held_n;
	logic                           pend_q, pend_n;
	logic                           tprev_q, tprev_n;
	logic                           tsticky_q, tsticky_n;
	logic                           chg_q, chg_n;
	logic [7:0]                     txsh_q, txsh_n;
	logic                           line_q, line_n;
	logic                           done_c;
	logic [ubr_pkg::COUNT_W-1:0]    rx_period, rx_first, rx_stop, tx_period;

	assign rx_period = ubr_pkg::at_least_one({1'b0, cfg.rx_bit_ticks});
	assign rx_first  = ubr_pkg::at_least_one({1'b0, cfg.rx_bit_ticks}
		+ {2'b0, cfg.rx_bit_ticks[ubr_pkg::TICK_W-1:1]});
	assign rx_stop   = ubr_pkg::at_least_one({cfg.rx_bit_ticks, 1'b0});
	assign tx_period = ubr_pkg::at_least_one({1'b0, cfg.tx_bit_ticks});
	assign tick_dec  = tick_q - ubr_pkg::COUNT_W'(1);
	assign bit_inc   = bit_q + 4'd1;

	always_comb begin
		phase_n   = phase_q;
		tick_n    = tick_q;
		bit_n     = bit_q;
		rxsh_n    = rxsh_q;
		held_n    = held_q;
		pend_n    = pend_q;
		tsticky_n = tsticky_q;
		chg_n     = chg_q;
		txsh_n    = txsh_q;
		line_n    = line_q;
		done_c    = 1'b0;

		// trigger edge is seen before the rest of the tick
		if (trig && !tprev_q) begin
			pend_n    = 1'b1;
			tsticky_n = 1'b1;
		end
		tprev_n = trig;

		unique case (phase_q)
			PH_RX_BITS: begin
				tick_n = tick_dec;
				if (tick_dec == '0) begin
					if (rx)
						rxsh_n[bit_q[2:0]] = 1'b1;
					if (bit_q >= 4'd7) begin
						phase_n = PH_RX_STOP;
						tick_n  = rx_stop;
					end else begin
						bit_n  = bit_inc;
						tick_n = rx_period;
					end
				end
			end
			PH_RX_STOP: begin
				tick_n = tick_dec;
				if (tick_dec == '0) begin
					done_c = 1'b1;
					if (rxsh_q != held_q) begin
						held_n = rxsh_q;
						chg_n  = 1'b1;
					end
					if (pend_n) begin
						phase_n = PH_TX_INIT;
						bit_n   = 4'd0;
						txsh_n  = ubr_pkg::INIT_BYTE;
						line_n  = 1'b0;
						tick_n  = tx_period;
					end else begin
						phase_n = PH_IDLE;
						bit_n   = 4'd0;
					end
				end
			end
			PH_TX_INIT, PH_TX_DATA: begin
				tick_n = tick_dec;
				if (tick_dec == '0) begin
					bit_n  = bit_inc;
					tick_n = tx_period;
					if (bit_inc >= 4'd1 && bit_inc <= 4'd8) begin
						line_n = txsh_q[0];
						txsh_n = {1'b0, txsh_q[7:1]};
					end else if (bit_inc == 4'd9) begin
						line_n = 1'b1;
					end else if (bit_inc == 4'd10 && phase_q == PH_TX_INIT) begin
						line_n = 1'b1; // gap between the two frames
					end else if (phase_q == PH_TX_INIT) begin
						phase_n = PH_TX_DATA;
						bit_n   = 4'd0;
						txsh_n  = held_q;
						line_n  = 1'b0;
					end else begin
						// end of relay: the clear beats any trigger seen meanwhile
						phase_n = PH_IDLE;
						bit_n   = 4'd0;
						tick_n  = '0;
						pend_n  = 1'b0;
					end
				end
			end
			default: begin
				phase_n = PH_IDLE;
				if (!rx) begin
					phase_n = PH_RX_BITS;
					bit_n   = 4'd0;
					rxsh_n  = 8'h00;
					tick_n  = rx_first;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tick_q    <= '0;
			bit_q     <= 4'd0;
			rxsh_q    <= 8'h00;
			held_q    <= 8'h00;
			pend_q    <= 1'b0;
			tprev_q   <= 1'b0;
			tsticky_q <= 1'b0;
			chg_q     <= 1'b0;
			txsh_q    <= 8'h00;
			line_q    <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_n;
			tick_q    <= tick_n;
			bit_q     <= bit_n;
			rxsh_q    <= rxsh_n;
			held_q    <= held_n;
			pend_q    <= pend_n;
			tprev_q   <= tprev_n;
			tsticky_q <= tsticky_n;
			chg_q     <= chg_n;
			txsh_q    <= txsh_n;
			line_q    <= line_n;
		end
	end

	assign res.tx_level     = line_n;
	assign res.trigger_seen = tsticky_n;
	assign res.held_byte    = held_n;
	assign res.byte_changed = chg_n;
	assign res.byte_done    = done_c;

endmodule

// ===== rtl/ubr_in_stage.sv =====
// Input register of the UART byte relay: one tick beat, valid/stall handshake.
// Depends on ubr_pkg only through the top level; no package items used here.
module ubr_in_stage (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic rx_level,
	input  logic trigger_level,
	input  logic advance,
	output logic valid_s1,
	output logic rx_s1,
	output logic trig_s1
);

	logic vld_s1;

	// hold the beat while the result side cannot take it
	assign in_stall = vld_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (!in_stall)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_s1   <= rx_level;
			trig_s1 <= trigger_level;
		end
	end

	assign valid_s1 = vld_s1;

endmodule

// ===== rtl/ubr_out_reg.sv =====
// Result register of the UART byte relay: holds one result beat until taken.
// Depends on ubr_pkg for the result struct.
module ubr_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  ubr_pkg::ubr_result_t  res,
	output logic                  advance,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ubr_pkg::ubr_result_t  out_res
);

	logic                 vld_s2;
	ubr_pkg::ubr_result_t res_s2;

	assign advance = valid_s1 && (!vld_s2 || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			res_s2 <= '0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
			res_s2 <= res;
		end else if (!out_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	assign out_valid = vld_s2;
	assign out_res   = res_s2;

endmodule

// ===== rtl/uart_byte_relay_on_trigger_top.sv =====
// Top level of the UART byte relay: 8N1 receiver that relays the held byte
// after a trigger. Depends on ubr_pkg, ubr_cfg, ubr_in_stage, ubr_core, ubr_out_reg.
//
// Usage:
//   Input channel: one beat per line tick, carrying rx_level and trigger_level
//   (in_valid / in_stall). Output channel: one result beat per input beat,
//   carrying tx_level, trigger_seen, held_byte, byte_changed and byte_done
//   (out_valid / out_stall). Bit timing counts beats, not clock cycles.
//   Configuration: write rx_bit_ticks (index 0) or tx_bit_ticks (index 1) with
//   cfg_we; write only while no beats are in flight.
//   Path: an accepted beat passes the input register, then the result register,
//   before its result shows. Throughput: one beat per cycle while out_stall is low;
//   the receive/transmit state updates once per beat.
//   Stall: while out_stall holds a result, one more beat waits in the input
//   register and then in_stall rises; nothing is dropped.
//   Reset: both bit periods return to 500 and 104 ticks, the sequencer waits
//   for a start bit, all sticky flags clear and the transmit line reads low
//   until the first data bit of a relay.
module uart_byte_relay_on_trigger_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ubr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ubr_pkg::TICK_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           rx_level,
	input  logic                           trigger_level,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           tx_level,
	output logic                           trigger_seen,
	output logic [7:0]                     held_byte,
	output logic                           byte_changed,
	output logic                           byte_done
);

	ubr_pkg::ubr_cfg_t    cfg;
	ubr_pkg::ubr_result_t res;
	ubr_pkg::ubr_result_t out_res;
	logic                 advance;
	logic                 valid_s1;
	logic                 rx_s1;
	logic                 trig_s1;

	ubr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ubr_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_level      (rx_level),
		.trigger_level (trigger_level),
		.advance       (advance),
		.valid_s1      (valid_s1),
		.rx_s1         (rx_s1),
		.trig_s1       (trig_s1)
	);

	ubr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.rx     (rx_s1),
		.trig   (trig_s1),
		.cfg    (cfg),
		.res    (res)
	);

	ubr_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign tx_level     = out_res.tx_level;
	assign trigger_seen = out_res.trigger_seen;
	assign held_byte    = out_res.held_byte;
	assign byte_changed = out_res.byte_changed;
	assign byte_done    = out_res.byte_done;

endmodule

// ===== rtl/ubr_checker.sv =====
// Port-level checks for the UART byte relay, bound to the top level.
// Depends on uart_byte_relay_on_trigger_top port names.
module ubr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       tx_level,
	input logic       trigger_seen,
	input logic [7:0] held_byte,
	input logic       byte_changed,
	input logic       byte_done
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(held_byte) && $stable(tx_level)
			&& $stable(byte_done))
		else $error("result beat changed while stalled");

	a_trig_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(trigger_seen))
		else $error("trigger_seen dropped");

	a_chg_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(byte_changed))
		else $error("byte_changed dropped");

	a_held_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(held_byte) |-> out_valid && byte_done && byte_changed)
		else $error("held_byte moved without a completed byte");

endmodule

bind uart_byte_relay_on_trigger_top ubr_checker u_ubr_checker (.*);
